[rtl/nbc_pkg.sv]
package nbc_pkg;

  localparam int BLOCK_WIDTH = 32;
  localparam int KEY_WIDTH   = 64;
  localparam int KEY_IDX_W   = 6;

  // 5-input nonlinear function, one bit per select code
  localparam logic [31:0] NLF_TABLE = 32'h3A5C_742E;

  // command codes
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // register byte offsets (one 8-byte slot per register)
  localparam logic [3:0] ADDR_CIPHER_KEY = 4'h0;

  // one encryption round: shift right, feed bit 31
  function automatic logic [BLOCK_WIDTH-1:0] enc_round(input logic [BLOCK_WIDTH-1:0] x,
                                                       input logic kb);
    logic [4:0] sel;
    logic       fb;
    sel = {x[31], x[26], x[20], x[9], x[1]};
    fb  = x[0] ^ x[16] ^ kb ^ NLF_TABLE[sel];
    return {fb, x[BLOCK_WIDTH-1:1]};
  endfunction

  // one decryption round: shift left, feed bit 0
  function automatic logic [BLOCK_WIDTH-1:0] dec_round(input logic [BLOCK_WIDTH-1:0] x,
                                                       input logic kb);
    logic [4:0] sel;
    logic       fb;
    sel = {x[30], x[25], x[19], x[8], x[0]};
    fb  = x[31] ^ x[15] ^ kb ^ NLF_TABLE[sel];
    return {x[BLOCK_WIDTH-2:0], fb};
  endfunction

endpackage

[rtl/nlfsr_block_cipher_encdec_unit.sv]
// KeeLoq-style NLFSR block cipher, 32-bit block, 64-bit key, encrypt or decrypt per
// beat. Raise start with cmd (0 encrypt, 1 decrypt) and block_in; busy is low except
// during reset, so a new beat may be issued every cycle. Each beat comes back on
// block_out with a one-cycle done strobe after the input register and all NUM_STAGES
// stage registers, in issue order; the receiver cannot stall, so take done when it
// comes. Throughput is one block per clock, set by the fully unrolled round
// pipeline: one input register plus NUM_STAGES stages of ROUNDS_PER_STAGE rounds
// each. The key lives in an APB register at byte offset 0 (64-bit data); write it
// only while no beat is in flight, since every stage reads it live.
module nlfsr_block_cipher_encdec_unit
  import nbc_pkg::*;
#(
  parameter int ROUND_COUNT      = 528,
  parameter int ROUNDS_PER_STAGE = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // command channel
  input  logic                   start,
  output logic                   busy,
  input  logic                   cmd,
  input  logic [BLOCK_WIDTH-1:0] block_in,
  // result channel
  output logic                   done,
  output logic [BLOCK_WIDTH-1:0] block_out,
  // APB configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [KEY_WIDTH-1:0]   pwdata,
  output logic [KEY_WIDTH-1:0]   prdata,
  output logic                   pready
);

  localparam int NUM_STAGES = (ROUND_COUNT + ROUNDS_PER_STAGE - 1) / ROUNDS_PER_STAGE;

  logic [KEY_WIDTH-1:0] cipher_key;

  // slot 0 is the input register, slot NUM_STAGES drives the result ports
  logic [NUM_STAGES:0]    vld;
  logic                   cmd_q  [0:NUM_STAGES];
  logic [BLOCK_WIDTH-1:0] data_q [0:NUM_STAGES];

  // ---------------------------------------------------------------------------
  // Configuration: only register index 0 exists; paddr[3] picks the 8-byte slot
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
    end else if (psel && penable && pwrite && (paddr[3] == ADDR_CIPHER_KEY[3])) begin
      cipher_key <= pwdata;
    end
  end

  always_comb begin
    if (paddr[3] == ADDR_CIPHER_KEY[3]) begin
      prdata = cipher_key;
    end else begin
      prdata = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: take a beat every cycle outside reset
  // ---------------------------------------------------------------------------
  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q[0]  <= cmd;
    data_q[0] <= block_in;
  end

  // ---------------------------------------------------------------------------
  // Round pipeline: each stage applies ROUNDS_PER_STAGE rounds. Key bit index is a
  // constant per round position: round mod 64 for encryption, and
  // (ROUND_COUNT - 1 - round) mod 64 for decryption. Padding rounds past
  // ROUND_COUNT in the last stage pass the block through.
  // ---------------------------------------------------------------------------
  for (genvar s = 1; s <= NUM_STAGES; s++) begin : g_stage
    logic [BLOCK_WIDTH-1:0] chain [0:ROUNDS_PER_STAGE];

    assign chain[0] = data_q[s-1];

    for (genvar j = 0; j < ROUNDS_PER_STAGE; j++) begin : g_round
      localparam int RND = (s - 1) * ROUNDS_PER_STAGE + j;
      localparam logic [KEY_IDX_W-1:0] ENC_KIDX = KEY_IDX_W'(RND % KEY_WIDTH);
      localparam logic [KEY_IDX_W-1:0] DEC_KIDX =
        KEY_IDX_W'((((ROUND_COUNT - 1 - RND) % KEY_WIDTH) + KEY_WIDTH) % KEY_WIDTH);

      if (RND < ROUND_COUNT) begin : g_live
        always_comb begin
          if (cmd_q[s-1] == CMD_DECRYPT) begin
            chain[j+1] = dec_round(chain[j], cipher_key[DEC_KIDX]);
          end else begin
            chain[j+1] = enc_round(chain[j], cipher_key[ENC_KIDX]);
          end
        end
      end else begin : g_pad
        assign chain[j+1] = chain[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= vld[s-1];
      end
    end

    // advance payload unconditionally; valid bits mark what is real
    always_ff @(posedge clk) begin
      cmd_q[s]  <= cmd_q[s-1];
      data_q[s] <= chain[ROUNDS_PER_STAGE];
    end
  end

  // ---------------------------------------------------------------------------
  // Result: one-cycle strobe straight from the last stage register
  // ---------------------------------------------------------------------------
  assign done      = vld[NUM_STAGES];
  assign block_out = data_q[NUM_STAGES];

endmodule

[rtl/nbc_chk.sv]
module nbc_chk
  import nbc_pkg::*;
#(
  parameter int ROUND_COUNT      = 528,
  parameter int ROUNDS_PER_STAGE = 8
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input logic                   psel,
  input logic                   penable,
  input logic                   pready
);

  localparam int LATENCY =
    (ROUND_COUNT + ROUNDS_PER_STAGE - 1) / ROUNDS_PER_STAGE + 1;

  // accept window opens as soon as reset drops
  a_busy_only_in_reset: assert property (@(posedge clk) busy == rst)
    else $error("busy does not follow reset");

  // no result may leave right after reset
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("done strobe right after reset");

  // every accepted beat returns a done strobe
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted beat produced no result");

  // no result without a matching accepted beat
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##LATENCY !done)
    else $error("result without an accepted beat");

  a_apb_ready: assert property (@(posedge clk) (psel && penable) |-> pready)
    else $error("access phase without pready");

endmodule

bind nlfsr_block_cipher_encdec_unit nbc_chk #(
  .ROUND_COUNT      (ROUND_COUNT),
  .ROUNDS_PER_STAGE (ROUNDS_PER_STAGE)
) u_nbc_chk (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .psel    (psel),
  .penable (penable),
  .pready  (pready)
);
